// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL. Each one samples on clk and is
// disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every clock edge.
`define ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// When ante holds, cons must hold in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// When ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, prop)
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/atin_pkg.sv =====
package atin_pkg;

    // One table row: word 0 is altitude, then east wind, north wind,
    // density, temperature and pressure.
    typedef logic [5:0][31:0] row_t;

    // Command carried in tuser on the input side.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Result status carried in tuser on the output side.
    typedef enum logic [1:0] {
        STAT_INTERP = 2'd0,
        STAT_LOW    = 2'd1,
        STAT_HIGH   = 2'd2,
        STAT_EMPTY  = 2'd3
    } status_t;

    localparam int ROW_BITS = 192;
    localparam int OUT_FIELDS = 5;

    // Extend a value word to 33 bits; the two wind words are signed.
    function automatic logic signed [32:0] ext33(input logic [31:0] w,
                                                 input logic [2:0] idx);
        logic is_signed;
        is_signed = (idx == 3'd1) || (idx == 3'd2);
        return $signed({is_signed & w[31], w});
    endfunction

endpackage

// ===== rtl/atin_divider.sv =====
// Restoring divider: one quotient bit per cycle. The numerator never
// exceeds the denominator, so the quotient has FRAC+1 bits.
module atin_divider #(
    parameter int FRAC = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [31:0]     num,
    input  logic [31:0]     den,
    output logic            done,
    output logic [FRAC:0]   quotient
);
    localparam int CW = $clog2(FRAC + 2);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [32:0]     rem_reg, rem_next;
    logic [31:0]     den_reg, den_next;
    logic [FRAC:0]   q_reg, q_next;
    logic            ge;
    logic [32:0]     rem_sub;

    // One compare and subtract per cycle.
    always_comb
    begin
        ge        = rem_reg >= {1'b0, den_reg};
        rem_sub   = ge ? rem_reg - {1'b0, den_reg} : rem_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(FRAC);
            rem_next  = {1'b0, num};
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = {rem_sub[31:0], 1'b0};
            q_next   = {q_reg[FRAC-1:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== rtl/atmosphere_table_interpolator_core.sv =====
// Channel  Dir  Signals                  Contents
// s        in   s_tvalid/tready/tdata    row write or altitude query (cmd in tuser)
// m        out  m_tvalid/tready/tdata    interpolated fields (status in tuser)
// cfg      in   cfg_wr_en/cfg_wr_data    rows_in_use
//
// A row write leaves the sequencer in its idle state. A query on an empty table
// goes straight to the result; one clamped low checks row 0, and one clamped high
// also checks the last row. Any other query takes longer, set by the single read
// port of the row memory in the binary search, the bit-serial divider and the one
// shared multiplier. Input is taken only while the sequencer is idle; a finished
// result waits in the output register while the next item is accepted, and a
// result that finishes while that register is still full waits until it drains.
// Reset is asynchronous.
`include "assert_macros.svh"
module atmosphere_table_interpolator_core #(
    parameter int TABLE_DEPTH   = 1024,
    parameter int FRACTION_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [9:0] row_index, [41:10] altitude, [73:42] wind_east_in,
    // [105:74] wind_north_in, [137:106] density_in,
    // [169:138] temperature_in, [201:170] pressure_in, [207:202] zero
    input  logic [207:0] s_tdata,
    // [0] cmd
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] wind_east_out, [63:32] wind_north_out, [95:64] density_out,
    // [127:96] temperature_out, [159:128] pressure_out
    output logic [159:0] m_tdata,
    // [1:0] lookup_status
    output logic [1:0]   m_tuser,
    input  logic         cfg_wr_en,
    input  logic [10:0]  cfg_wr_data
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = 33 + FRACTION_BITS + 2;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b000000000001,
        ST_CHK0   = 12'b000000000010,
        ST_CHKN   = 12'b000000000100,
        ST_SEARCH = 12'b000000001000,
        ST_SCMP   = 12'b000000010000,
        ST_LDA    = 12'b000000100000,
        ST_LDB    = 12'b000001000000,
        ST_PREP   = 12'b000010000000,
        ST_DIV    = 12'b000100000000,
        ST_MUL    = 12'b001000000000,
        ST_ADD    = 12'b010000000000,
        ST_EMIT   = 12'b100000000000
    } state_t;

    state_t                      state_reg, state_next;
    logic [10:0]                 rows_reg;
    logic [NW-1:0]               n_reg, n_next, n_sat;
    logic signed [31:0]          h_reg, h_next;
    logic [AW-1:0]               lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [AW-1:0]               rd_addr, mid_calc;
    atin_pkg::row_t              mem [TABLE_DEPTH];
    atin_pkg::row_t              rd_data_reg, row_a_reg, row_a_next, row_b_reg, row_b_next;
    logic [FRACTION_BITS:0]      t_reg, t_next;
    logic signed [PW-1:0]        prod_reg, prod_next;
    logic [2:0]                  fld_reg, fld_next, widx;
    logic [4:0][31:0]            res_reg, res_next;
    atin_pkg::status_t           stat_reg, stat_next;
    logic                        m_valid_reg, m_valid_next;
    logic [159:0]                m_data_reg, m_data_next;
    logic [1:0]                  m_user_reg, m_user_next;
    logic                        div_start, div_done;
    logic [FRACTION_BITS:0]      div_q;
    logic signed [32:0]          den_calc, num_calc, diff, a_ext;
    logic [31:0]                 num_clamp;
    logic signed [PW-1:0]        shifted;
    logic                        wr_en;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rows_reg <= '0;
        else if (cfg_wr_en)
            rows_reg <= cfg_wr_data;
    end

    assign n_sat = (32'(rows_reg) > 32'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(rows_reg);

    // Row memory: one write port, one registered read port.
    assign wr_en = s_tvalid && s_tready && (s_tuser == atin_pkg::CMD_WRITE)
                   && (32'(s_tdata[9:0]) < 32'(TABLE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[AW'(s_tdata[9:0])] <= s_tdata[201:10];
        rd_data_reg <= mem[rd_addr];
    end

    atin_divider #(
        .FRAC (FRACTION_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (num_clamp),
        .den      (den_calc[31:0]),
        .done     (div_done),
        .quotient (div_q)
    );

    // Shared datapath pieces.
    always_comb
    begin
        mid_calc  = lo_reg + ((hi_reg - lo_reg) >> 1);
        den_calc  = $signed({row_b_reg[0][31], row_b_reg[0]})
                    - $signed({row_a_reg[0][31], row_a_reg[0]});
        num_calc  = $signed({h_reg[31], h_reg}) - $signed({row_a_reg[0][31], row_a_reg[0]});
        if (num_calc[32])
            num_clamp = '0;
        else if (num_calc > den_calc)
            num_clamp = den_calc[31:0];
        else
            num_clamp = num_calc[31:0];
        widx      = fld_reg + 3'd1;
        a_ext     = atin_pkg::ext33(row_a_reg[widx], widx);
        diff      = atin_pkg::ext33(row_b_reg[widx], widx) - a_ext;
        shifted   = prod_reg >>> FRACTION_BITS;
    end

    // Query sequencer.
    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        h_next       = h_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        row_a_next   = row_a_reg;
        row_b_next   = row_b_reg;
        t_next       = t_reg;
        prod_next    = prod_reg;
        fld_next     = fld_reg;
        res_next     = res_reg;
        stat_next    = stat_reg;
        rd_addr      = '0;
        div_start    = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tuser == atin_pkg::CMD_QUERY)
                begin
                    h_next = $signed(s_tdata[41:10]);
                    n_next = n_sat;
                    if (n_sat == '0)
                    begin
                        res_next   = '0;
                        stat_next  = atin_pkg::STAT_EMPTY;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_CHK0;
                    end
                end
            end
            ST_CHK0:
            begin
                if (h_reg <= $signed(rd_data_reg[0]))
                begin
                    res_next   = rd_data_reg[5:1];
                    stat_next  = atin_pkg::STAT_LOW;
                    state_next = ST_EMIT;
                end
                else
                begin
                    rd_addr    = AW'(n_reg - NW'(1));
                    state_next = ST_CHKN;
                end
            end
            ST_CHKN:
            begin
                if (h_reg >= $signed(rd_data_reg[0]) || n_reg == NW'(1))
                begin
                    res_next   = rd_data_reg[5:1];
                    stat_next  = atin_pkg::STAT_HIGH;
                    state_next = ST_EMIT;
                end
                else
                begin
                    lo_next    = AW'(1);
                    hi_next    = AW'(n_reg - NW'(1));
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_addr    = mid_calc;
                    mid_next   = mid_calc;
                    state_next = ST_SCMP;
                end
                else
                begin
                    rd_addr    = lo_reg - AW'(1);
                    state_next = ST_LDA;
                end
            end
            ST_SCMP:
            begin
                if ($signed(rd_data_reg[0]) < h_reg)
                    lo_next = mid_reg + AW'(1);
                else
                    hi_next = mid_reg;
                state_next = ST_SEARCH;
            end
            ST_LDA:
            begin
                row_a_next = rd_data_reg;
                rd_addr    = lo_reg;
                state_next = ST_LDB;
            end
            ST_LDB:
            begin
                row_b_next = rd_data_reg;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                fld_next = '0;
                if (den_calc[32] || den_calc == '0)
                begin
                    t_next     = '0;
                    state_next = ST_MUL;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    t_next     = div_q;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = PW'(diff * $signed({1'b0, t_reg}));
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                res_next[fld_reg] = 32'(a_ext + shifted[32:0]);
                if (fld_reg == 3'(atin_pkg::OUT_FIELDS - 1))
                begin
                    stat_next  = atin_pkg::STAT_INTERP;
                    state_next = ST_EMIT;
                end
                else
                begin
                    fld_next   = fld_reg + 3'd1;
                    state_next = ST_MUL;
                end
            end
            ST_EMIT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    m_user_next  = stat_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        h_reg      <= h_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        row_a_reg  <= row_a_next;
        row_b_reg  <= row_b_next;
        t_reg      <= t_next;
        prod_reg   <= prod_next;
        fld_reg    <= fld_next;
        res_reg    <= res_next;
        stat_reg   <= stat_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // The search window never inverts.
    `ASSERT_IMPLIES(a_search_window, state_reg == ST_SEARCH, lo_reg <= hi_reg)
    // A result leaving the sequencer is on the output in the next cycle.
    `ASSERT_NEXT(a_emit_valid, state_reg == ST_EMIT && (!m_valid_reg || m_tready), m_tvalid)
    // The divider answers only while the sequencer waits for it.
    `ASSERT_IMPLIES(a_div_owner, div_done, state_reg == ST_DIV)
    // The quotient never exceeds one in fixed point.
    `ASSERT_IMPLIES(a_div_range, div_done, div_q <= (FRACTION_BITS + 1)'(1) << FRACTION_BITS)

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int DEPTH = 1024;
    localparam int FRAC = 16;
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT = 2000000;

    // Kind of a stimulus table entry.
    typedef enum logic {
        ENT_ITEM = 1'b0,
        ENT_CFG  = 1'b1
    } entry_kind_t;

    typedef struct packed {
        logic [4:0][31:0]  vals;
        atin_pkg::status_t stat;
    } lookup_t;

    typedef struct packed {
        entry_kind_t      kind;
        logic             cmd;
        logic [9:0]       idx;
        logic [31:0]      alt;
        logic [4:0][31:0] vals;
        logic             typed;
        lookup_t          typed_res;
    } entry_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [207:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_wr_en;
    logic [10:0]  cfg_wr_data;

    // Shadow copy of the table and the row count.
    logic [31:0]      alt_shadow[DEPTH];
    logic [4:0][31:0] val_shadow[DEPTH];
    int unsigned      rows_shadow;

    lookup_t lookups_pending[$];
    entry_t  directed[$];
    int      mismatches = 0;
    int      send_idle_pct;
    int      recv_idle_pct;
    longint  cycles = 0;

    atmosphere_table_interpolator_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Clock with a 10 ns period.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("atmosphere_table_interpolator_core test failed");
            $finish;
        end
    end

    // Receiver stalls at random.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Word j of a row as a 64-bit number; the two winds are signed.
    function automatic longint field_value(logic [31:0] w, int j);
        if (j < 2)
            return longint'($signed(w));
        return longint'({32'b0, w});
    endfunction

    function automatic lookup_t interpolate_lookup(logic [31:0] h_raw);
        lookup_t      res;
        int unsigned  n;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        longint       h;
        longint       ha;
        longint       hb;
        longint       num;
        longint       den;
        longint       t;
        longint       a;
        longint       b;
        longint       prod;
        n = (rows_shadow > DEPTH) ? DEPTH : rows_shadow;
        h = longint'($signed(h_raw));
        res = '0;
        if (n == 0)
        begin
            res.stat = atin_pkg::STAT_EMPTY;
            return res;
        end
        if (h <= longint'($signed(alt_shadow[0])))
        begin
            res.vals = val_shadow[0];
            res.stat = atin_pkg::STAT_LOW;
            return res;
        end
        if (h >= longint'($signed(alt_shadow[n - 1])) || n == 1)
        begin
            res.vals = val_shadow[n - 1];
            res.stat = atin_pkg::STAT_HIGH;
            return res;
        end
        // Binary search for the first row at or above h.
        lo = 1;
        hi = n - 1;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (longint'($signed(alt_shadow[mid])) < h)
                lo = mid + 1;
            else
                hi = mid;
        end
        ha = longint'($signed(alt_shadow[lo - 1]));
        hb = longint'($signed(alt_shadow[lo]));
        den = hb - ha;
        num = h - ha;
        if (den <= 0)
            t = 0;
        else
        begin
            if (num < 0)
                num = 0;
            if (num > den)
                num = den;
            t = (num <<< FRAC) / den;
        end
        for (int j = 0; j < 5; j++)
        begin
            a = field_value(val_shadow[lo - 1][j], j);
            b = field_value(val_shadow[lo][j], j);
            prod = t * (b - a);
            res.vals[j] = 32'(a + (prod >>> FRAC));
        end
        res.stat = atin_pkg::STAT_INTERP;
        return res;
    endfunction

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        lookup_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (lookups_pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: data %h status %0d", m_tdata, m_tuser);
            end
            else
            begin
                want = lookups_pending.pop_front();
                if (m_tdata !== want.vals || m_tuser !== want.stat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%0d, got %h/%0d",
                                 want.vals, want.stat, m_tdata, m_tuser);
                end
            end
        end
    end

    // Drive one item, starting at a falling edge, and record it when it is taken.
    task automatic send_item(logic cmd, logic [9:0] idx, logic [31:0] alt,
                             logic [4:0][31:0] vals, logic typed, lookup_t typed_res);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'b0, vals, alt, idx};
        do
            @(posedge clk);
        while (!s_tready);
        if (cmd == atin_pkg::CMD_WRITE)
        begin
            alt_shadow[idx] = alt;
            val_shadow[idx] = vals;
        end
        else if (typed)
            lookups_pending = {lookups_pending, typed_res};
        else
            lookups_pending = {lookups_pending, interpolate_lookup(alt)};
        @(negedge clk);
    endtask

    // Let the block drain, then write the row count.
    task automatic write_rows_in_use(logic [10:0] value);
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (lookups_pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        rows_shadow = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic add_entry(entry_kind_t kind, logic cmd, logic [9:0] idx,
                             logic [31:0] alt, logic [4:0][31:0] vals,
                             logic typed, logic [4:0][31:0] tvals,
                             atin_pkg::status_t tstat);
        entry_t e;
        e.kind = kind;
        e.cmd = cmd;
        e.idx = idx;
        e.alt = alt;
        e.vals = vals;
        e.typed = typed;
        e.typed_res.vals = tvals;
        e.typed_res.stat = tstat;
        directed = {directed, e};
    endtask

    // Load a fresh non-descending table into rows 0..n-1.
    task automatic load_table(int unsigned n);
        longint           a;
        longint           step_max;
        logic [4:0][31:0] vals;
        step_max = 64'hFFFF0000 / n;
        a = -64'sd2147483648 + $urandom_range(65535);
        for (int unsigned r = 0; r < n; r++)
        begin
            for (int j = 0; j < 5; j++)
                vals[j] = $urandom;
            send_item(atin_pkg::CMD_WRITE, r[9:0], 32'(a), vals, 1'b0, '0);
            if ($urandom_range(9) != 0)
                a = a + $urandom_range(32'(step_max), 1);
        end
    endtask

    task automatic random_queries(int count);
        int unsigned n;
        int unsigned j;
        int          pick;
        longint      ha;
        longint      gap;
        logic [31:0] h;
        n = (rows_shadow > DEPTH) ? DEPTH : rows_shadow;
        for (int q = 0; q < count; q++)
        begin
            pick = $urandom_range(9);
            if (n == 0 || pick == 0)
                h = $urandom;
            else if (pick == 1 || n == 1)
                h = alt_shadow[$urandom_range(n - 1)];
            else
            begin
                j = $urandom_range(n - 2);
                ha = longint'($signed(alt_shadow[j]));
                gap = longint'($signed(alt_shadow[j + 1])) - ha;
                h = 32'(ha + ({$urandom, $urandom} % (gap + 1)));
            end
            send_item(atin_pkg::CMD_QUERY, 10'($urandom), h, '0, 1'b0, '0);
        end
    endtask

    localparam logic [31:0] ALT_MIN = 32'h8000_0000;
    localparam logic [31:0] ALT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] ALT_TOP = 32'h7000_0000;

    initial
    begin
        logic [4:0][31:0] row0;
        logic [4:0][31:0] row1;
        int               sizes[11];
        entry_t           e;

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        rows_shadow = 0;
        send_idle_pct = 21;
        recv_idle_pct = 51;

        row0 = {32'h1234_5678, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        row1 = {32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};

        // Directed part: empty table, single row, extremes, non-ascending rows, oversized row count.
        // A configuration entry carries the row count in its altitude column.
        add_entry(ENT_ITEM, atin_pkg::CMD_QUERY, 10'd0, 32'd0, '0, 1'b1, '0,
                  atin_pkg::STAT_EMPTY);
        add_entry(ENT_ITEM, atin_pkg::CMD_QUERY, 10'h3FF, ALT_MIN, '0, 1'b1, '0,
                  atin_pkg::STAT_EMPTY);
        add_entry(ENT_ITEM, atin_pkg::CMD_QUERY, 10'd0, ALT_MAX, '1, 1'b1, '0,
                  atin_pkg::STAT_EMPTY);
        add_entry(ENT_ITEM, atin_pkg::CMD_WRITE, 10'd0, -32'sd1000, row0, 1'b0, '0,
                  atin_pkg::STAT_INTERP);
        add_entry(ENT_ITEM, atin_pkg::CMD_WRITE, 10'd1, 32'd1000, row1, 1'b0, '0,
                  atin_pkg::STAT_INTERP);
        add_entry(ENT_CFG, atin_pkg::CMD_WRITE, 10'd0, 32'd1, '0, 1'b0, '0,
                  atin_pkg::STAT_INTERP);
        add_entry(ENT_ITEM, atin_pkg::CMD_QUERY, 10'd0, ALT_MIN, '0, 1'b1, row0,
                  atin_pkg::STAT_LOW);
        add_entry(ENT_ITEM, atin_pkg::CMD_QUERY, 10'd0, -32'sd1000, '0, 1'b1, row0,
                  atin_pkg::STAT_LOW);
        add_entry(ENT_ITEM, atin_pkg::CMD_QUERY, 10'd0, ALT_MAX, '0, 1'b1, row0,
                  atin_pkg::STAT_HIGH);
        add_entry(ENT_CFG, atin_pkg::CMD_WRITE, 10'd0, 32'd2, '0, 1'b0, '0,
                  atin_pkg::STAT_INTERP);
        add_entry(ENT_ITEM, atin_pkg::CMD_QUERY, 10'd0, 32'd0, '0, 1'b0, '0,
                  atin_pkg::STAT_INTERP);
        add_entry(ENT_ITEM, atin_pkg::CMD_QUERY, 10'd0, 32'd999, '0, 1'b0, '0,
                  atin_pkg::STAT_INTERP);
        add_entry(ENT_ITEM, atin_pkg::CMD_QUERY, 10'd0, -32'sd999, '0, 1'b0, '0,
                  atin_pkg::STAT_INTERP);
        add_entry(ENT_ITEM, atin_pkg::CMD_QUERY, 10'd0, 32'd1000, '0, 1'b1, row1,
                  atin_pkg::STAT_HIGH);
        add_entry(ENT_ITEM, atin_pkg::CMD_QUERY, 10'd0, ALT_MAX, '0, 1'b1, row1,
                  atin_pkg::STAT_HIGH);
        // A row below its neighbor makes the table non-ascending.
        add_entry(ENT_ITEM, atin_pkg::CMD_WRITE, 10'd2, 32'd500,
                  {32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA},
                  1'b0, '0, atin_pkg::STAT_INTERP);
        add_entry(ENT_ITEM, atin_pkg::CMD_WRITE, 10'd3, 32'd3000,
                  {32'd3, 32'd2, 32'd1, 32'hFFFF_FFFF, 32'd0}, 1'b0, '0,
                  atin_pkg::STAT_INTERP);
        add_entry(ENT_CFG, atin_pkg::CMD_WRITE, 10'd0, 32'd4, '0, 1'b0, '0,
                  atin_pkg::STAT_INTERP);
        add_entry(ENT_ITEM, atin_pkg::CMD_QUERY, 10'd0, 32'd700, '0, 1'b0, '0,
                  atin_pkg::STAT_INTERP);
        add_entry(ENT_ITEM, atin_pkg::CMD_QUERY, 10'd0, 32'd1500, '0, 1'b0, '0,
                  atin_pkg::STAT_INTERP);
        add_entry(ENT_ITEM, atin_pkg::CMD_QUERY, 10'd0, 32'd2999, '0, 1'b0, '0,
                  atin_pkg::STAT_INTERP);
        add_entry(ENT_ITEM, atin_pkg::CMD_QUERY, 10'd0, 32'd3000, '0, 1'b0, '0,
                  atin_pkg::STAT_INTERP);
        // An oversized row count saturates to the last row; only clamped queries.
        add_entry(ENT_ITEM, atin_pkg::CMD_WRITE, 10'h3FF, ALT_TOP, row1, 1'b0, '0,
                  atin_pkg::STAT_INTERP);
        add_entry(ENT_CFG, atin_pkg::CMD_WRITE, 10'd0, 32'd2047, '0, 1'b0, '0,
                  atin_pkg::STAT_INTERP);
        add_entry(ENT_ITEM, atin_pkg::CMD_QUERY, 10'd0, ALT_MIN, '0, 1'b1, row0,
                  atin_pkg::STAT_LOW);
        add_entry(ENT_ITEM, atin_pkg::CMD_QUERY, 10'd0, ALT_TOP, '0, 1'b0, '0,
                  atin_pkg::STAT_INTERP);
        add_entry(ENT_ITEM, atin_pkg::CMD_QUERY, 10'd0, ALT_MAX, '0, 1'b1, row1,
                  atin_pkg::STAT_HIGH);
        add_entry(ENT_CFG, atin_pkg::CMD_WRITE, 10'd0, 32'd1024, '0, 1'b0, '0,
                  atin_pkg::STAT_INTERP);
        add_entry(ENT_ITEM, atin_pkg::CMD_QUERY, 10'd0, ALT_MAX, '0, 1'b0, '0,
                  atin_pkg::STAT_INTERP);

        // Hold reset, then release it at a falling edge.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            e = directed[i];
            if (e.kind == ENT_CFG)
                write_rows_in_use(11'(e.alt));
            else
                send_item(e.cmd, e.idx, e.alt, e.vals, e.typed, e.typed_res);
        end

        // Random phases over freshly loaded tables, including an empty one.
        sizes = '{2, 7, 1, 40, 3, 100, 0, 13, 60, 5, 30};
        foreach (sizes[p])
        begin
            if (p == 4)
            begin
                send_idle_pct = 51;
                recv_idle_pct = 21;
            end
            else if (p == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_rows_in_use(11'(sizes[p]));
            if (sizes[p] > 0 && sizes[p] <= DEPTH)
                load_table(sizes[p]);
            random_queries(23);
        end

        // Drain and finish.
        s_tvalid <= 1'b0;
        while (lookups_pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0 && lookups_pending.size() == 0)
            $display("atmosphere_table_interpolator_core test passed");
        else
            $display("atmosphere_table_interpolator_core test failed");
        $finish;
    end

endmodule
